// ===== rtl/frustum_plane_culling_unit_macros.svh =====
// assertion macros used by the frustum culling plane cell
`ifndef FRUSTUM_PLANE_CULLING_UNIT_MACROS_SVH
`define FRUSTUM_PLANE_CULLING_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FPC_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("frustum culling check failed");

// next-cycle implication
`define FPC_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("frustum culling check failed");

`else

`define FPC_ASSERT_IMPLY(lbl, ck, rs, ante, cons)
`define FPC_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== rtl/fpc_pkg.sv =====
// types, widths and codes of the frustum culling unit
package fpc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_REGS = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int PLANE_W    = 64;
  localparam int COORD_W    = 16;
  localparam int PROD_W     = 2 * COORD_W;
  localparam int D_SHIFT    = 14;
  localparam int SUM_W      = PROD_W + 3;

  localparam logic [1:0] REQ_POINT   = 2'd0;
  localparam logic [1:0] REQ_SEGMENT = 2'd1;
  localparam logic [1:0] REQ_BOX     = 2'd2;

  localparam logic [1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [1:0] VERDICT_OUTSIDE   = 2'd1;
  localparam logic [1:0] VERDICT_INTERSECT = 2'd2;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [COORD_W-1:0]  ax;
    logic signed [COORD_W-1:0]  ay;
    logic signed [COORD_W-1:0]  az;
    logic signed [COORD_W-1:0]  bx;
    logic signed [COORD_W-1:0]  by;
    logic signed [COORD_W-1:0]  bz;
  } item_t;

  // running classification carried along the chain
  typedef struct packed {
    logic       any_a;
    logic       any_b;
    logic       both;
    logic       done;
    logic [1:0] verdict;
  } acc_t;

  localparam acc_t ACC_CLEAR = '{any_a: 1'b0, any_b: 1'b0, both: 1'b0, done: 1'b0,
                                 verdict: VERDICT_INSIDE};

endpackage

// ===== rtl/fpc_req_if.sv =====
// request channel: query type and two corner points
interface fpc_req_if import fpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [COORD_W-1:0] ax;
  logic signed [COORD_W-1:0] ay;
  logic signed [COORD_W-1:0] az;
  logic signed [COORD_W-1:0] bx;
  logic signed [COORD_W-1:0] by;
  logic signed [COORD_W-1:0] bz;

  modport source (output valid, req_type, ax, ay, az, bx, by, bz, input ready);
  modport sink   (input valid, req_type, ax, ay, az, bx, by, bz, output ready);
endinterface

// ===== rtl/fpc_res_if.sv =====
// result channel: culling verdict
interface fpc_res_if import fpc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

// ===== rtl/fpc_cell.sv =====
// one plane cell: holds a plane, multiplies, then sums and folds the result in
`include "frustum_plane_culling_unit_macros.svh"

module fpc_cell import fpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [PLANE_W-1:0] wr_data,
  input  logic               up_valid,
  input  item_t              up_item,
  input  acc_t               up_acc,
  output logic               up_ready,
  output logic               dn_valid,
  output item_t              dn_item,
  output acc_t               dn_acc,
  input  logic               dn_ready
);

  logic [PLANE_W-1:0] plane;

  logic signed [COORD_W-1:0] nx, ny, nz, d;
  logic                      box;
  logic signed [COORD_W-1:0] pax, pay, paz, pbx, pby, pbz;

  // stage 1 registers
  logic                     v1;
  item_t                    item1;
  acc_t                     acc1;
  logic signed [PROD_W-1:0] max_p, may_p, maz_p, mbx_p, mby_p, mbz_p;

  // stage 2 registers
  logic  v2;
  item_t item2;
  acc_t  acc2;

  logic               en1, en2;
  logic signed [SUM_W-1:0] d_term, sum_a, sum_b;
  logic               out_a, out_b;
  acc_t               acc_next;

  assign nx = $signed(plane[15:0]);
  assign ny = $signed(plane[31:16]);
  assign nz = $signed(plane[47:32]);
  assign d  = $signed(plane[63:48]);

  always_ff @(posedge clk) begin
    if (rst) begin
      plane <= '0;
    end else if (wr_en) begin
      plane <= wr_data;
    end
  end

  assign en2      = !v2 || dn_ready;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  // box queries swap corners per axis where the normal is negative
  assign box = !(up_item.req_type inside {REQ_POINT, REQ_SEGMENT});

  always_comb begin
    pax = up_item.ax;  pbx = up_item.bx;
    pay = up_item.ay;  pby = up_item.by;
    paz = up_item.az;  pbz = up_item.bz;
    if (box && nx[COORD_W-1]) begin
      pax = up_item.bx;  pbx = up_item.ax;
    end
    if (box && ny[COORD_W-1]) begin
      pay = up_item.by;  pby = up_item.ay;
    end
    if (box && nz[COORD_W-1]) begin
      paz = up_item.bz;  pbz = up_item.az;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item1 <= up_item;
      acc1  <= up_acc;
      max_p <= nx * pax;
      may_p <= ny * pay;
      maz_p <= nz * paz;
      mbx_p <= nx * pbx;
      mby_p <= ny * pby;
      mbz_p <= nz * pbz;
    end
  end

  // exact plane value, d rescaled from q8.8 to the product scale
  assign d_term = SUM_W'($signed({d, {D_SHIFT{1'b0}}}));
  assign sum_a  = SUM_W'(max_p) + SUM_W'(may_p) + SUM_W'(maz_p) + d_term;
  assign sum_b  = SUM_W'(mbx_p) + SUM_W'(mby_p) + SUM_W'(mbz_p) + d_term;
  assign out_a  = !sum_a[SUM_W-1] && (sum_a != '0);
  assign out_b  = !sum_b[SUM_W-1] && (sum_b != '0);

  always_comb begin
    acc_next       = acc1;
    acc_next.any_a = acc1.any_a || out_a;
    acc_next.any_b = acc1.any_b || out_b;
    acc_next.both  = acc1.both || (out_a && out_b);
    if (!acc1.done) begin
      if (out_a) begin
        acc_next.done    = 1'b1;
        acc_next.verdict = VERDICT_OUTSIDE;
      end else if (out_b) begin
        acc_next.done    = 1'b1;
        acc_next.verdict = VERDICT_INTERSECT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      item2 <= item1;
      acc2  <= acc_next;
    end
  end

  assign dn_valid = v2;
  assign dn_item  = item2;
  assign dn_acc   = acc2;

  `FPC_ASSERT_NEXT(a_stall_holds, clk, rst, v2 && !dn_ready, v2 && $stable(acc2))
  `FPC_ASSERT_NEXT(a_decided_kept, clk, rst, v1 && en2 && acc1.done,
                   acc2.done && (acc2.verdict == $past(acc1.verdict)))
  `FPC_ASSERT_IMPLY(a_shared_bit, clk, rst, v2 && acc2.both, acc2.any_a && acc2.any_b)

endmodule

// ===== rtl/fpc_out.sv =====
// final verdict resolution and output register
module fpc_out import fpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  input  item_t     up_item,
  input  acc_t      up_acc,
  output logic      up_ready,
  fpc_res_if.source res
);

  logic       valid;
  logic [1:0] verdict;
  logic [1:0] verdict_next;

  always_comb begin
    case (up_item.req_type)
      REQ_POINT: begin
        verdict_next = up_acc.any_a ? VERDICT_OUTSIDE : VERDICT_INSIDE;
      end
      REQ_SEGMENT: begin
        if (!up_acc.any_a && !up_acc.any_b) begin
          verdict_next = VERDICT_INSIDE;
        end else if (up_acc.both) begin
          verdict_next = VERDICT_OUTSIDE;
        end else begin
          verdict_next = VERDICT_INTERSECT;
        end
      end
      default: begin
        verdict_next = up_acc.done ? up_acc.verdict : VERDICT_INSIDE;
      end
    endcase
  end

  assign up_ready = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      verdict <= verdict_next;
    end
  end

  assign res.valid   = valid;
  assign res.verdict = verdict;

endmodule

// ===== rtl/frustum_plane_culling_unit.sv =====
// frustum culling unit: top level with the plane cell chain and output stage
//
// classifies a point, a segment or an axis-aligned box against six planes
// (left, right, bottom, top, near, far), each held in the cell that tests it.
// one query is taken per clock cycle while the chain is not stalled; each plane
// cell registers its products, then its sum and compare result, and the output
// register follows the last cell; with the result side stalled the chain keeps
// absorbing queries until its bubbles are filled. plane registers are to be
// written through cfg_we / cfg_idx / cfg_data only while no query is in flight,
// which the unit itself does not enforce; indexes past the last plane are ignored.
// verdict codes: inside, outside, intersecting
module frustum_plane_culling_unit import fpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  fpc_req_if.sink              req,
  fpc_res_if.source            res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [PLANE_W-1:0]   cfg_data
);

  // chain links: link 0 is the request side, link NUM_PLANES feeds the output
  logic  link_valid [NUM_PLANES+1];
  logic  link_ready [NUM_PLANES+1];
  item_t link_item  [NUM_PLANES+1];
  acc_t  link_acc   [NUM_PLANES+1];

  assign link_valid[0] = req.valid;
  assign link_item[0]  = '{req_type: req.req_type, ax: req.ax, ay: req.ay, az: req.az,
                           bx: req.bx, by: req.by, bz: req.bz};
  assign link_acc[0]   = ACC_CLEAR;
  assign req.ready     = link_ready[0];

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    logic wr_en;

    // planes beyond the register list are never written and stay zero
    assign wr_en = cfg_we && (i < PLANE_REGS) && (cfg_idx == CFG_IDX_W'(i));

    fpc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr_en    (wr_en),
      .wr_data  (cfg_data),
      .up_valid (link_valid[i]),
      .up_item  (link_item[i]),
      .up_acc   (link_acc[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_item  (link_item[i+1]),
      .dn_acc   (link_acc[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  // output register parts the chain from the result transaction
  fpc_out u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (link_valid[NUM_PLANES]),
    .up_item  (link_item[NUM_PLANES]),
    .up_acc   (link_acc[NUM_PLANES]),
    .up_ready (link_ready[NUM_PLANES]),
    .res      (res)
  );

endmodule
